### rtl/assert_macros.svh
// Assertion macros shared by the landmark pair distance and angle unit.
// Depends on nothing; the SYNTH define removes the checks for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### rtl/lpda_pkg.sv
// Types and constants of the landmark pair distance and angle unit.
// Used by every module of the unit; depends on nothing.
`timescale 1ns / 1ps

package lpda_pkg;

    localparam int IDX_W      = 7;
    localparam int SLOT_W     = 13;
    localparam int DIST_W     = 18;
    localparam int ANG_W      = 15;
    localparam int ZW         = 33;
    localparam int ITERS      = 28;
    localparam int FRAC_SHIFT = 20;
    localparam int ROUND_SHIFT = 17;

    localparam logic [DIST_W-1:0]       DIST_MAX    = 18'd262143;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q13 = 15'sd12868;
    localparam logic signed [ZW-1:0]    ROUND_BIAS  = 33'sd65536;

    typedef struct packed {
        logic vert;
        logic horiz;
        logic dy_pos;
    } t_flags;

    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        logic signed [ZW-1:0] v;
        unique case (i)
            0:       v = 33'sd843314857;
            1:       v = 33'sd497837829;
            2:       v = 33'sd263043837;
            3:       v = 33'sd133525159;
            4:       v = 33'sd67021687;
            5:       v = 33'sd33543516;
            6:       v = 33'sd16775851;
            7:       v = 33'sd8388437;
            8:       v = 33'sd4194283;
            9:       v = 33'sd2097149;
            10:      v = 33'sd1048576;
            default: v = 33'sd1 <<< (30 - i);
        endcase
        return v;
    endfunction

endpackage

### rtl/lpda_front.sv
// Front stages: coordinate differences, squares, slot number and CORDIC start vector.
// Depends on lpda_pkg.
`timescale 1ns / 1ps

module lpda_front #(
    parameter int COORD_BITS = 13
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [COORD_BITS-1:0]      i_point_a_x,
    input  logic signed [COORD_BITS-1:0]      i_point_a_y,
    input  logic signed [COORD_BITS-1:0]      i_point_b_x,
    input  logic signed [COORD_BITS-1:0]      i_point_b_y,
    input  logic [lpda_pkg::IDX_W-1:0]        i_index_a,
    input  logic [lpda_pkg::IDX_W-1:0]        i_index_b,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [2*COORD_BITS+9:0]           o_rad,
    output logic signed [COORD_BITS+22:0]     o_x,
    output logic signed [COORD_BITS+22:0]     o_y,
    output lpda_pkg::t_flags                  o_flags,
    output logic [lpda_pkg::SLOT_W-1:0]       o_slot
);
    import lpda_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int XW = COORD_BITS + 23;
    localparam int RW = 2 * COORD_BITS + 10;

    logic                r_v0, r_v1, r_v2;
    logic                w_rdy0, w_rdy1, w_rdy2;

    logic signed [CB:0]  r_dx, r_dy;
    logic [IDX_W-1:0]    r_a0, r_b0, r_b1;

    logic [2*CB-1:0]     r_sqx, r_sqy;
    logic signed [CB:0]  r_cx, r_cy;
    t_flags              r_flags1;
    logic [SLOT_W-1:0]   r_prod;

    logic [RW-1:0]       r_rad;
    logic signed [XW-1:0] r_x, r_y;
    t_flags              r_flags2;
    logic [SLOT_W-1:0]   r_slot;

    logic signed [CB:0]  w_dx, w_dy, w_cx, w_cy;
    logic [CB-1:0]       w_ux, w_uy;
    logic [2*IDX_W-1:0]  w_prod;
    t_flags              w_flags;

    assign w_rdy2  = !r_v2 || i_ready;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign w_rdy0  = !r_v0 || w_rdy1;
    assign o_ready = w_rdy0;

    assign w_dx = $signed({i_point_a_x[CB-1], i_point_a_x})
                - $signed({i_point_b_x[CB-1], i_point_b_x});
    assign w_dy = $signed({i_point_a_y[CB-1], i_point_a_y})
                - $signed({i_point_b_y[CB-1], i_point_b_y});

    always_comb begin
        w_flags.vert   = (r_dx == '0);
        w_flags.horiz  = (r_dy == '0);
        w_flags.dy_pos = (r_dy > 0);
        w_cx   = r_dx[CB] ? -r_dx : r_dx;
        w_cy   = r_dx[CB] ? -r_dy : r_dy;
        w_ux   = w_cx[CB-1:0];
        w_uy   = r_dy[CB] ? CB'(-r_dy) : r_dy[CB-1:0];
        w_prod = {{IDX_W{1'b0}}, r_a0} * {{IDX_W{1'b0}}, r_a0 - IDX_W'(1)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy0) begin
                r_v0 <= i_valid;
            end
            if (w_rdy1) begin
                r_v1 <= r_v0;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy0 && i_valid) begin
            r_dx <= w_dx;
            r_dy <= w_dy;
            r_a0 <= i_index_a;
            r_b0 <= i_index_b;
        end
        if (w_rdy1 && r_v0) begin
            r_sqx    <= {{CB{1'b0}}, w_ux} * {{CB{1'b0}}, w_ux};
            r_sqy    <= {{CB{1'b0}}, w_uy} * {{CB{1'b0}}, w_uy};
            r_cx     <= w_cx;
            r_cy     <= w_cy;
            r_flags1 <= w_flags;
            r_prod   <= w_prod[SLOT_W-1:0];
            r_b1     <= r_b0;
        end
        if (w_rdy2 && r_v1) begin
            r_rad    <= {1'b0, {1'b0, r_sqx} + {1'b0, r_sqy}, 8'b0};
            r_x      <= XW'(r_cx) <<< FRAC_SHIFT;
            r_y      <= XW'(r_cy) <<< FRAC_SHIFT;
            r_flags2 <= r_flags1;
            r_slot   <= r_prod + {{(SLOT_W-IDX_W-1){1'b0}}, r_b1, 1'b0};
        end
    end

    assign o_valid = r_v2;
    assign o_rad   = r_rad;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_flags = r_flags2;
    assign o_slot  = r_slot;

endmodule

### rtl/lpda_cell.sv
// Chain cell: a vectoring CORDIC rotation and, if ITER < RT, a square root digit.
// Depends on lpda_pkg.
`timescale 1ns / 1ps

module lpda_cell #(
    parameter int ITER       = 0,
    parameter int COORD_BITS = 13
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [2*COORD_BITS+9:0]           i_rad,
    input  logic [COORD_BITS+4:0]             i_root,
    input  logic [COORD_BITS+6:0]             i_rem,
    input  logic signed [COORD_BITS+22:0]     i_x,
    input  logic signed [COORD_BITS+22:0]     i_y,
    input  logic signed [lpda_pkg::ZW-1:0]    i_z,
    input  lpda_pkg::t_flags                  i_flags,
    input  logic [lpda_pkg::SLOT_W-1:0]       i_slot,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [2*COORD_BITS+9:0]           o_rad,
    output logic [COORD_BITS+4:0]             o_root,
    output logic [COORD_BITS+6:0]             o_rem,
    output logic signed [COORD_BITS+22:0]     o_x,
    output logic signed [COORD_BITS+22:0]     o_y,
    output logic signed [lpda_pkg::ZW-1:0]    o_z,
    output lpda_pkg::t_flags                  o_flags,
    output logic [lpda_pkg::SLOT_W-1:0]       o_slot
);
    import lpda_pkg::*;

    localparam int XW = COORD_BITS + 23;
    localparam int RT = COORD_BITS + 5;
    localparam int RW = 2 * COORD_BITS + 10;
    localparam logic signed [ZW-1:0] ANG = atan_q30(ITER);

    logic                 r_v;
    logic                 w_adv;
    logic [RW-1:0]        r_rad, n_rad;
    logic [RT-1:0]        r_root, n_root;
    logic [RT+1:0]        r_rem, n_rem;
    logic signed [XW-1:0] r_x, r_y, n_x, n_y;
    logic signed [ZW-1:0] r_z, n_z;
    t_flags               r_flags;
    logic [SLOT_W-1:0]    r_slot;

    assign w_adv   = !r_v || i_ready;
    assign o_ready = w_adv;

    always_comb begin
        if (i_y > 0) begin
            n_x = i_x + (i_y >>> ITER);
            n_y = i_y - (i_x >>> ITER);
            n_z = i_z + ANG;
        end else begin
            n_x = i_x - (i_y >>> ITER);
            n_y = i_y + (i_x >>> ITER);
            n_z = i_z - ANG;
        end
    end

    generate
        if (ITER < RT) begin : g_sqrt
            logic [RT+1:0] w_part, w_trial;
            always_comb begin
                w_part  = {i_rem[RT-1:0], i_rad[RW-1 -: 2]};
                w_trial = {i_root, 2'b01};
                n_rad   = {i_rad[RW-3:0], 2'b00};
                if (w_part >= w_trial) begin
                    n_rem  = w_part - w_trial;
                    n_root = {i_root[RT-2:0], 1'b1};
                end else begin
                    n_rem  = w_part;
                    n_root = {i_root[RT-2:0], 1'b0};
                end
            end
        end else begin : g_pass
            assign n_rad  = i_rad;
            assign n_rem  = i_rem;
            assign n_root = i_root;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_adv) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_rad   <= n_rad;
            r_root  <= n_root;
            r_rem   <= n_rem;
            r_x     <= n_x;
            r_y     <= n_y;
            r_z     <= n_z;
            r_flags <= i_flags;
            r_slot  <= i_slot;
        end
    end

    assign o_valid = r_v;
    assign o_rad   = r_rad;
    assign o_root  = r_root;
    assign o_rem   = r_rem;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_flags = r_flags;
    assign o_slot  = r_slot;

endmodule

### rtl/lpda_back.sv
// Output stage: rounds and saturates distance and angle and holds the result.
// Depends on lpda_pkg.
`timescale 1ns / 1ps

module lpda_back #(
    parameter int COORD_BITS = 13
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [COORD_BITS+4:0]             i_root,
    input  logic [COORD_BITS+6:0]             i_rem,
    input  logic signed [lpda_pkg::ZW-1:0]    i_z,
    input  lpda_pkg::t_flags                  i_flags,
    input  logic [lpda_pkg::SLOT_W-1:0]       i_slot,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [lpda_pkg::SLOT_W-1:0]       o_feature_index,
    output logic [lpda_pkg::DIST_W-1:0]       o_distance,
    output logic signed [lpda_pkg::ANG_W-1:0] o_angle
);
    import lpda_pkg::*;

    localparam int RT = COORD_BITS + 5;
    localparam int DW = (RT + 1 > DIST_W) ? RT + 1 : DIST_W;
    localparam int QW = ZW - ROUND_SHIFT;
    localparam logic signed [QW-1:0] Q_MAX = QW'(16383);
    localparam logic signed [QW-1:0] Q_MIN = -QW'(16384);

    logic                       r_v;
    logic                       w_adv;
    logic [SLOT_W-1:0]          r_slot;
    logic [DIST_W-1:0]          r_dist, n_dist;
    logic signed [ANG_W-1:0]    r_ang, n_ang;
    logic [DW-1:0]              w_round;
    logic signed [ZW-1:0]       w_zr;
    logic signed [QW-1:0]       w_q;

    assign w_adv   = !r_v || i_ready;
    assign o_ready = w_adv;

    always_comb begin
        w_round = DW'(i_root) + DW'(i_rem > {2'b00, i_root});
        n_dist  = (w_round > DW'(DIST_MAX)) ? DIST_MAX : w_round[DIST_W-1:0];
        w_zr    = i_z + ROUND_BIAS;
        w_q     = w_zr[ZW-1:ROUND_SHIFT];
        if (i_flags.vert) begin
            n_ang = i_flags.dy_pos ? HALF_PI_Q13 : -HALF_PI_Q13;
        end else if (i_flags.horiz) begin
            n_ang = '0;
        end else if (w_q > Q_MAX) begin
            n_ang = ANG_W'(Q_MAX);
        end else if (w_q < Q_MIN) begin
            n_ang = ANG_W'(Q_MIN);
        end else begin
            n_ang = w_q[ANG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_adv) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_slot <= i_slot;
            r_dist <= n_dist;
            r_ang  <= n_ang;
        end
    end

    assign o_valid         = r_v;
    assign o_feature_index = r_slot;
    assign o_distance      = r_dist;
    assign o_angle         = r_ang;

endmodule

### rtl/landmark_pair_distance_angle_unit.sv
// Top level of the landmark pair distance and angle unit.
// Depends on lpda_pkg, lpda_front, lpda_cell, lpda_back and assert_macros.svh.
//
// The unit takes one landmark pair per cycle, unless the output stalls it, and returns its
// feature slot a*(a-1)+2*b, the rounded Euclidean distance in unsigned Q14.4 and the slope
// angle in signed Q2.13 radians, one result per pair and in order. Each pair passes through
// three front stages, a chain of 28 cells that each perform one CORDIC rotation and, in the
// first COORD_BITS+5 cells, one square root digit, and an output register. Throughput is one
// pair per cycle while the output is not stalled, and empty slots in the chain close up while
// the output is stalled.
`timescale 1ns / 1ps

module landmark_pair_distance_angle_unit #(
    parameter int COORD_BITS = 13
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [COORD_BITS-1:0]      i_point_a_x,
    input  logic signed [COORD_BITS-1:0]      i_point_a_y,
    input  logic signed [COORD_BITS-1:0]      i_point_b_x,
    input  logic signed [COORD_BITS-1:0]      i_point_b_y,
    input  logic [lpda_pkg::IDX_W-1:0]        i_index_a,
    input  logic [lpda_pkg::IDX_W-1:0]        i_index_b,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [lpda_pkg::SLOT_W-1:0]       o_feature_index,
    output logic [lpda_pkg::DIST_W-1:0]       o_distance,
    output logic signed [lpda_pkg::ANG_W-1:0] o_angle
);
    import lpda_pkg::*;

    `include "assert_macros.svh"

    localparam int XW = COORD_BITS + 23;
    localparam int RT = COORD_BITS + 5;
    localparam int RW = 2 * COORD_BITS + 10;

    logic                 w_valid [ITERS+1];
    logic                 w_ready [ITERS+1];
    logic [RW-1:0]        w_rad   [ITERS+1];
    logic [RT-1:0]        w_root  [ITERS+1];
    logic [RT+1:0]        w_rem   [ITERS+1];
    logic signed [XW-1:0] w_x     [ITERS+1];
    logic signed [XW-1:0] w_y     [ITERS+1];
    logic signed [ZW-1:0] w_z     [ITERS+1];
    t_flags               w_flags [ITERS+1];
    logic [SLOT_W-1:0]    w_slot  [ITERS+1];

    assign w_root[0] = '0;
    assign w_rem[0]  = '0;
    assign w_z[0]    = '0;

    lpda_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_point_a_x (i_point_a_x),
        .i_point_a_y (i_point_a_y),
        .i_point_b_x (i_point_b_x),
        .i_point_b_y (i_point_b_y),
        .i_index_a   (i_index_a),
        .i_index_b   (i_index_b),
        .o_valid     (w_valid[0]),
        .i_ready     (w_ready[0]),
        .o_rad       (w_rad[0]),
        .o_x         (w_x[0]),
        .o_y         (w_y[0]),
        .o_flags     (w_flags[0]),
        .o_slot      (w_slot[0])
    );

    generate
        for (genvar g = 0; g < ITERS; g++) begin : g_cell
            lpda_cell #(
                .ITER       (g),
                .COORD_BITS (COORD_BITS)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_valid[g]),
                .o_ready (w_ready[g]),
                .i_rad   (w_rad[g]),
                .i_root  (w_root[g]),
                .i_rem   (w_rem[g]),
                .i_x     (w_x[g]),
                .i_y     (w_y[g]),
                .i_z     (w_z[g]),
                .i_flags (w_flags[g]),
                .i_slot  (w_slot[g]),
                .o_valid (w_valid[g+1]),
                .i_ready (w_ready[g+1]),
                .o_rad   (w_rad[g+1]),
                .o_root  (w_root[g+1]),
                .o_rem   (w_rem[g+1]),
                .o_x     (w_x[g+1]),
                .o_y     (w_y[g+1]),
                .o_z     (w_z[g+1]),
                .o_flags (w_flags[g+1]),
                .o_slot  (w_slot[g+1])
            );
        end
    endgenerate

    lpda_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_valid[ITERS]),
        .o_ready         (w_ready[ITERS]),
        .i_root          (w_root[ITERS]),
        .i_rem           (w_rem[ITERS]),
        .i_z             (w_z[ITERS]),
        .i_flags         (w_flags[ITERS]),
        .i_slot          (w_slot[ITERS]),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_feature_index (o_feature_index),
        .o_distance      (o_distance),
        .o_angle         (o_angle)
    );

    // A pair of coincident points has no slope and must report the negative vertical angle.
    `ASSERT_IMPLY(a_zero_dist_angle, i_clk, i_rst_n, o_valid && (o_distance == '0), o_angle == -HALF_PI_Q13)
    `ASSERT_IMPLY(a_angle_range, i_clk, i_rst_n, o_valid, (o_angle <= HALF_PI_Q13) && (o_angle >= -HALF_PI_Q13))
    `ASSERT_IMPLY(a_ready_when_drained, i_clk, i_rst_n, !o_valid, o_ready)

endmodule
